[hdl/ofip_pkg.sv]
// shared types, character codes and field decode functions for the face index parser
package ofip_pkg;

    localparam int unsigned IndexW  = 32;
    localparam int unsigned FieldW  = 4;
    localparam int unsigned CornerW = 2;
    localparam int unsigned KindW   = 2;

    localparam logic [7:0] ChSlash = 8'd47;
    localparam logic [7:0] ChSpace = 8'd32;
    localparam logic [7:0] ChCr    = 8'd13;
    localparam logic [7:0] ChZero  = 8'd48;

    typedef enum logic [1:0] {
        FMT_VTN = 2'd0,
        FMT_VVN = 2'd1,
        FMT_VT  = 2'd2,
        FMT_V3  = 2'd3
    } t_format;

    typedef struct packed {
        logic [IndexW-1:0]  index_value;
        logic [CornerW-1:0] corner;
        logic [KindW-1:0]   kind;
        logic               line_done;
        logic               short_line;
    } t_result;

    // index of the last field of a line
    function automatic logic [FieldW-1:0] last_field(input t_format fmt);
        logic [FieldW-1:0] r;
        unique case (fmt)
            FMT_VTN: r = 4'd8;
            FMT_V3:  r = 4'd2;
            default: r = 4'd5;
        endcase
        return r;
    endfunction

    // position inside a v/t/n corner
    function automatic logic [1:0] mod3(input logic [FieldW-1:0] f);
        logic [1:0] r;
        case (f)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [CornerW-1:0] corner_of(input t_format fmt,
                                                     input logic [FieldW-1:0] f);
        logic [CornerW-1:0] r;
        unique case (fmt)
            FMT_VTN: begin
                if (f < 4'd3) r = 2'd0;
                else if (f < 4'd6) r = 2'd1;
                else r = 2'd2;
            end
            FMT_V3:  r = f[1:0];
            default: r = f[2:1];
        endcase
        return r;
    endfunction

    function automatic logic [KindW-1:0] kind_of(input t_format fmt,
                                                 input logic [FieldW-1:0] f);
        logic [KindW-1:0] r;
        unique case (fmt)
            FMT_VTN: r = mod3(f);
            FMT_VVN: r = f[0] ? 2'd2 : 2'd0;
            FMT_VT:  r = {1'b0, f[0]};
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] separator_of(input t_format fmt,
                                                input logic [FieldW-1:0] f);
        logic [7:0] r;
        unique case (fmt)
            FMT_VTN: r = (mod3(f) == 2'd2) ? ChSpace : ChSlash;
            FMT_V3:  r = ChSpace;
            default: r = f[0] ? ChSpace : ChSlash;
        endcase
        return r;
    endfunction

endpackage

[hdl/ofip_core.sv]
// line parsing state and per-byte next-state and result logic
module ofip_core
    import ofip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_eol,
    input  t_format     i_format,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [1:0]        r_prefix_cnt, n_prefix_cnt;
    logic [FieldW-1:0] r_field_num,  n_field_num;
    logic [IndexW-1:0] r_acc,        n_acc;
    logic              r_fresh,      n_fresh;
    logic              r_drop,       n_drop;
    logic              r_finished,   n_finished;

    logic [FieldW-1:0] w_last_f;
    logic [FieldW-1:0] w_f;
    logic              w_last;
    logic [IndexW-1:0] w_acc_step;
    logic              w_restart;

    assign w_last_f   = last_field(i_format);
    assign w_f        = (r_field_num < w_last_f) ? r_field_num : w_last_f;
    assign w_last     = (w_f == w_last_f);
    // acc*10 + byte - '0', wrapping
    assign w_acc_step = (r_acc << 3) + (r_acc << 1) + {24'd0, i_byte}
                        - {24'd0, ChZero};

    always_comb begin
        n_prefix_cnt = r_prefix_cnt;
        n_field_num  = r_field_num;
        n_acc        = r_acc;
        n_fresh      = r_fresh;
        n_drop       = r_drop;
        n_finished   = r_finished;
        w_restart    = 1'b0;
        o_res_valid  = 1'b0;
        o_res.index_value = r_acc;
        o_res.corner      = corner_of(i_format, w_f);
        o_res.kind        = kind_of(i_format, w_f);
        o_res.line_done   = 1'b1;
        o_res.short_line  = 1'b1;

        if (r_finished) begin
            // bytes after a carriage return
            w_restart = i_eol;
        end else if (r_prefix_cnt < 2'd2) begin
            n_prefix_cnt = r_prefix_cnt + 2'd1;
            if (i_eol) begin
                o_res_valid       = 1'b1;
                o_res.index_value = '0;
                o_res.corner      = '0;
                o_res.kind        = '0;
                w_restart         = 1'b1;
            end
        end else if (r_drop) begin
            n_drop  = 1'b0;
            n_fresh = 1'b0;
            if (i_eol) begin
                o_res_valid = 1'b1;
                w_restart   = 1'b1;
            end
        end else if (!r_fresh && w_last && i_byte == ChCr) begin
            o_res_valid      = 1'b1;
            o_res.short_line = 1'b0;
            if (i_eol) w_restart = 1'b1;
            else n_finished = 1'b1;
        end else if (!r_fresh && !w_last && i_byte == separator_of(i_format, w_f)) begin
            o_res_valid      = 1'b1;
            o_res.line_done  = i_eol;
            o_res.short_line = i_eol;
            if (i_eol) begin
                w_restart = 1'b1;
            end else begin
                n_acc       = '0;
                n_drop      = (i_format == FMT_VVN) && !w_f[0];
                n_field_num = w_f + 4'd1;
            end
        end else begin
            n_fresh = 1'b0;
            n_acc   = w_acc_step;
            if (i_eol) begin
                o_res_valid       = 1'b1;
                o_res.index_value = w_acc_step;
                o_res.short_line  = !w_last;
                w_restart         = 1'b1;
            end
        end

        if (w_restart) begin
            n_prefix_cnt = '0;
            n_field_num  = '0;
            n_acc        = '0;
            n_fresh      = 1'b1;
            n_drop       = 1'b0;
            n_finished   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_cnt <= '0;
            r_field_num  <= '0;
            r_acc        <= '0;
            r_fresh      <= 1'b1;
            r_drop       <= 1'b0;
            r_finished   <= 1'b0;
        end else if (i_step) begin
            r_prefix_cnt <= n_prefix_cnt;
            r_field_num  <= n_field_num;
            r_acc        <= n_acc;
            r_fresh      <= n_fresh;
            r_drop       <= n_drop;
            r_finished   <= n_finished;
        end
    end

    a_no_result_after_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_finished) |-> !o_res_valid)
        else $error("result produced after carriage return");

    a_eol_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_eol) |=> (r_prefix_cnt == 2'd0 && r_field_num == '0
                               && r_fresh && !r_drop && !r_finished))
        else $error("line state not restarted after end of line");

    a_short_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.line_done || !o_res.short_line))
        else $error("short line flag without line done");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_num <= 4'd8)
        else $error("field number out of range");

endmodule

[hdl/obj_face_index_parser.sv]
// top level of the face line index parser: stream ports, input and result registers
//
// Parses the index part of a face line one byte per transfer. The first two
// bytes of each line are dropped, the rest is split into index fields by '/'
// and ' ' according to face_format (0 v/t/n, 1 v//n, 2 v/t, 3 three values).
// Every finished field leaves as one result transfer with its value and corner
// in tdata; tuser carries the kind of the field and flags a line that ended
// before its last field began, and the last result of a line has tlast set.
// A carriage return closes the last field and all bytes up to the end-of-line
// byte are ignored. Throughput is one byte per cycle while the result side
// does not stall: a byte passes the input register, then compare and
// multiply-by-ten-add logic into the result register. Both registers advance
// whenever the result register is empty or being drained, so back-pressure
// from the result side stalls the input side only when both are full.
// face_format may only be written while no line is in flight.
module obj_face_index_parser
    import ofip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,      // face_format
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] line_byte
    input  logic        s_axis_tlast,    // end_of_line
    // index stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [31:0] index_value, [33:32] corner,
                                         // [39:34] zero
    output logic        m_axis_tlast,    // line_done
    output logic [2:0]  m_axis_tuser     // [1:0] kind, [2] short_line
);

    t_format    r_format;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eol;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_advance;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;

    // both stages move when the result register can take a new value
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_VTN;
        end else if (i_cfg_valid) begin
            r_format <= t_format'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eol  <= s_axis_tlast;
        end
    end

    ofip_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_eol       (r_in_eol),
        .i_format    (r_format),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step && w_res_valid;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.corner, r_out.index_value};
    assign m_axis_tlast  = r_out.line_done;
    assign m_axis_tuser  = {r_out.short_line, r_out.kind};

endmodule
